// ===== src/i2cm_pkg.sv =====
// Shared types, codes and the segment programs of the I2C register-access master.
`default_nettype none
package i2cm_pkg;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Command codes
  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_WB   = 3'd1;
  localparam logic [2:0] OP_WW   = 3'd2;
  localparam logic [2:0] OP_RB   = 3'd3;
  localparam logic [2:0] OP_RW   = 3'd4;

  // Bus segments
  localparam logic [3:0] SEG_START   = 4'd0;
  localparam logic [3:0] SEG_RESTART = 4'd1;
  localparam logic [3:0] SEG_STOP    = 4'd2;
  localparam logic [3:0] SEG_ADDRW   = 4'd3;
  localparam logic [3:0] SEG_ADDRR   = 4'd4;
  localparam logic [3:0] SEG_REG     = 4'd5;
  localparam logic [3:0] SEG_HI      = 4'd6;
  localparam logic [3:0] SEG_LO      = 4'd7;
  localparam logic [3:0] SEG_RXA     = 4'd8;
  localparam logic [3:0] SEG_RXN     = 4'd9;

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_FIRST = 4'd1;

  typedef logic [7:0][3:0] seg_row_t;

  // Element 0 is the first segment of the transaction
  localparam seg_row_t PROG_WB = {SEG_STOP, SEG_STOP, SEG_STOP, SEG_STOP,
                                  SEG_LO, SEG_REG, SEG_ADDRW, SEG_START};
  localparam seg_row_t PROG_WW = {SEG_STOP, SEG_STOP, SEG_STOP, SEG_LO,
                                  SEG_HI, SEG_REG, SEG_ADDRW, SEG_START};
  localparam seg_row_t PROG_RB = {SEG_STOP, SEG_STOP, SEG_RXN, SEG_ADDRR,
                                  SEG_RESTART, SEG_REG, SEG_ADDRW, SEG_START};
  localparam seg_row_t PROG_RW = {SEG_STOP, SEG_RXN, SEG_RXA, SEG_ADDRR,
                                  SEG_RESTART, SEG_REG, SEG_ADDRW, SEG_START};

  typedef struct packed {
    logic [2:0]  opcode;
    logic [6:0]  device_address;
    logic [7:0]  register_address;
    logic [15:0] write_data;
    logic        sda_sample;
  } in_item_t;

  typedef struct packed {
    logic        scl_level;
    logic        sda_pull_low;
    logic        busy_res;
    logic        done_res;
    logic        ack_ok;
    logic [15:0] read_word;
  } out_item_t;

  // Classified beat as it waits in the queue
  typedef struct packed {
    logic        is_cmd;
    logic [2:0]  op;
    logic [6:0]  dev;
    logic [7:0]  regad;
    logic [15:0] data;
    logic        sda;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic     nonempty;
    q_entry_t entry;
  } q_head_t;

  function automatic logic [3:0] seg_lookup(input logic [2:0] op, input logic [2:0] idx);
    logic [3:0] seg;
    case (op)
      OP_WB:   seg = PROG_WB[idx];
      OP_WW:   seg = PROG_WW[idx];
      OP_RB:   seg = PROG_RB[idx];
      OP_RW:   seg = PROG_RW[idx];
      default: seg = PROG_WB[idx];
    endcase
    return seg;
  endfunction

endpackage
`default_nettype wire

// ===== src/i2cm_front.sv =====
// Input side: accepts beats and classifies each as a command or a tick.
`default_nettype none
module i2cm_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire i2cm_pkg::in_item_t in_item,
  input  wire logic              q_full,
  output i2cm_pkg::q_push_t      push_o
);
  import i2cm_pkg::*;

  logic is_cmd;
  logic take;

  // Opcodes outside the command range act as ticks
  assign is_cmd = (in_item.opcode == OP_WB) || (in_item.opcode == OP_WW) ||
                  (in_item.opcode == OP_RB) || (in_item.opcode == OP_RW);

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  always_comb begin
    push_o             = '0;
    push_o.push        = take;
    push_o.entry.is_cmd = is_cmd;
    push_o.entry.op    = is_cmd ? in_item.opcode : OP_TICK;
    push_o.entry.dev   = in_item.device_address;
    push_o.entry.regad = in_item.register_address;
    push_o.entry.data  = in_item.write_data;
    push_o.entry.sda   = in_item.sda_sample;
  end

  // Command beats carry a legal opcode into the queue
  a_cmd_op: assert property (@(posedge clk) disable iff (!rst_n)
    push_o.push && push_o.entry.is_cmd |-> push_o.entry.op != OP_TICK)
    else $error("command beat lost its opcode");
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    push_o.push |-> !q_full)
    else $error("push into a full queue");
  a_tick_op: assert property (@(posedge clk) disable iff (!rst_n)
    push_o.push && !push_o.entry.is_cmd |-> push_o.entry.op == OP_TICK)
    else $error("tick beat carries a command code");

endmodule
`default_nettype wire

// ===== src/i2cm_queue.sv =====
// Short FIFO between the classifier and the bus sequencer.
`default_nettype none
module i2cm_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire i2cm_pkg::q_push_t push_i,
  input  wire logic              pop,
  output logic                   full,
  output i2cm_pkg::q_head_t      head_o
);
  import i2cm_pkg::*;

  q_entry_t          mem_r [QDepth];
  logic [QPtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0]  count_r, count_nxt;
  logic              do_pop;

  assign full   = (count_r == QCntW'(QDepth));
  assign do_pop = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i.push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push_i.push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push_i.push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i.push) begin
      mem_r[wr_ptr_r] <= push_i.entry;
    end
  end

  assign head_o.nonempty = (count_r != '0);
  assign head_o.entry    = mem_r[rd_ptr_r];

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCntW'(QDepth))
    else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full && !do_pop |-> !push_i.push)
    else $error("queue overflow");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> wr_ptr_r == rd_ptr_r)
    else $error("empty queue with pointer gap");

endmodule
`default_nettype wire

// ===== src/i2cm_seq.sv =====
// Bus sequencer: one queued beat per unstalled cycle runs SCL/SDA by segment program.
`default_nettype none
module i2cm_seq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [7:0]         tpp_cfg,
  input  wire i2cm_pkg::q_head_t  head_i,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output i2cm_pkg::out_item_t     out_item
);
  import i2cm_pkg::*;

  logic [3:0]  phase_r, phase_nxt;
  logic [1:0]  quarter_r, quarter_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [7:0]  tick_r, tick_nxt;
  logic [15:0] shift_r, shift_nxt;
  logic [2:0]  op_r, op_nxt;
  logic [6:0]  dev_r, dev_nxt;
  logic [7:0]  reg_r, reg_nxt;
  logic [15:0] data_r, data_nxt;
  logic        ack_r, ack_nxt;
  logic        out_valid_r;
  out_item_t   out_item_r;

  q_entry_t    e;
  out_item_t   res;
  logic        cmd_start, active, done;
  logic [2:0]  op_e;
  logic [6:0]  dev_e;
  logic [7:0]  reg_e;
  logic [15:0] data_e;
  logic [3:0]  phase_e, phase_m1, bit_e, bit_inc;
  logic [1:0]  q_e;
  logic [7:0]  tick_e, tpp;
  logic [15:0] shift_e;
  logic        ack_e;
  logic [3:0]  seg;
  logic        is_byte, is_tx, last, scl, pull;
  logic [7:0]  txbyte;
  logic [2:0]  bit_sel;

  assign e   = head_i.entry;
  assign pop = head_i.nonempty && (!out_valid_r || !out_stall);

  always_comb begin
    phase_nxt   = phase_r;
    quarter_nxt = quarter_r;
    bit_nxt     = bit_r;
    tick_nxt    = tick_r;
    shift_nxt   = shift_r;
    op_nxt      = op_r;
    dev_nxt     = dev_r;
    reg_nxt     = reg_r;
    data_nxt    = data_r;
    ack_nxt     = ack_r;

    cmd_start = e.is_cmd && (phase_r == PH_IDLE);
    active    = (phase_r != PH_IDLE) || cmd_start;

    // A new command starts from a fresh context in this same beat
    op_e    = cmd_start ? e.op    : op_r;
    dev_e   = cmd_start ? e.dev   : dev_r;
    reg_e   = cmd_start ? e.regad : reg_r;
    data_e  = cmd_start ? e.data  : data_r;
    phase_e = cmd_start ? PH_FIRST : phase_r;
    q_e     = cmd_start ? 2'd0 : quarter_r;
    bit_e   = cmd_start ? 4'd0 : bit_r;
    tick_e  = cmd_start ? 8'd0 : tick_r;
    shift_e = cmd_start ? 16'd0 : shift_r;
    ack_e   = cmd_start ? 1'b1 : ack_r;

    phase_m1 = phase_e - 4'd1;
    seg      = seg_lookup(op_e, phase_m1[2:0]);
    is_byte  = (seg >= SEG_ADDRW);
    is_tx    = is_byte && (seg <= SEG_LO);

    case (seg)
      SEG_ADDRW: txbyte = {dev_e, 1'b0};
      SEG_ADDRR: txbyte = {dev_e, 1'b1};
      SEG_REG:   txbyte = reg_e;
      SEG_HI:    txbyte = data_e[15:8];
      SEG_LO:    txbyte = data_e[7:0];
      default:   txbyte = 8'd0;
    endcase
    bit_sel = 3'd7 - bit_e[2:0];

    if (seg == SEG_START || seg == SEG_RESTART) begin
      scl  = (q_e == 2'd0) ? (seg == SEG_START) : (q_e != 2'd3);
      pull = (q_e >= 2'd2);
    end else if (seg == SEG_STOP) begin
      scl  = (q_e != 2'd0);
      pull = (q_e < 2'd2);
    end else begin
      scl = (q_e == 2'd1) || (q_e == 2'd2);
      if (bit_e < 4'd8) begin
        pull = is_tx && !txbyte[bit_sel];
      end else begin
        pull = (seg == SEG_RXA);
      end
    end

    tpp  = (tpp_cfg == 8'd0) ? 8'd1 : tpp_cfg;
    last = ({1'b0, tick_e} + 9'd1) >= {1'b0, tpp};

    // Sample SDA on the last tick of the second high quarter
    if (last && q_e == 2'd2 && is_byte) begin
      if (is_tx && bit_e >= 4'd8 && e.sda) begin
        ack_e = 1'b0;
      end
      if (!is_tx && bit_e < 4'd8) begin
        shift_e = {shift_e[14:0], e.sda};
      end
    end

    done    = 1'b0;
    bit_inc = bit_e + 4'd1;
    if (last) begin
      tick_e = 8'd0;
      if (q_e == 2'd3) begin
        q_e   = 2'd0;
        bit_e = bit_inc;
        if (bit_inc >= (is_byte ? 4'd9 : 4'd1)) begin
          bit_e = 4'd0;
          if (seg == SEG_STOP) begin
            done    = 1'b1;
            phase_e = PH_IDLE;
          end else begin
            phase_e = phase_e + 4'd1;
          end
        end
      end else begin
        q_e = q_e + 2'd1;
      end
    end else begin
      tick_e = tick_e + 8'd1;
    end

    res           = '0;
    res.scl_level = 1'b1;
    if (active) begin
      res.scl_level    = scl;
      res.sda_pull_low = pull;
      res.busy_res     = (phase_e != PH_IDLE);
      res.done_res     = done;
      res.ack_ok       = done && ack_e;
      if (done && op_e == OP_RB) begin
        res.read_word = {8'd0, shift_e[7:0]};
      end else if (done && op_e == OP_RW) begin
        res.read_word = shift_e;
      end
    end

    if (pop && active) begin
      phase_nxt   = phase_e;
      quarter_nxt = q_e;
      bit_nxt     = bit_e;
      tick_nxt    = tick_e;
      shift_nxt   = shift_e;
      ack_nxt     = ack_e;
      op_nxt      = op_e;
      dev_nxt     = dev_e;
      reg_nxt     = reg_e;
      data_nxt    = data_e;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      quarter_r   <= '0;
      bit_r       <= '0;
      tick_r      <= '0;
      shift_r     <= '0;
      op_r        <= OP_TICK;
      ack_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      quarter_r <= quarter_nxt;
      bit_r     <= bit_nxt;
      tick_r    <= tick_nxt;
      shift_r   <= shift_nxt;
      op_r      <= op_nxt;
      ack_r     <= ack_nxt;
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: hold the command and the result beat
  always_ff @(posedge clk) begin
    dev_r  <= dev_nxt;
    reg_r  <= reg_nxt;
    data_r <= data_nxt;
    if (pop) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.done_res |-> !out_item_r.busy_res)
    else $error("done reported while still busy");
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> quarter_r == 2'd0 && bit_r == 4'd0 && tick_r == 8'd0)
    else $error("idle with stale bit counters");
  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r <= 4'd8)
    else $error("bit index past the ack slot");
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= 4'd8)
    else $error("segment number out of range");
  a_ack_done_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.ack_ok |-> out_item_r.done_res)
    else $error("ack status outside done beat");

endmodule
`default_nettype wire

// ===== src/i2c_master_register_access_top.sv =====
// Top level of the I2C register-access master: classifier, queue and bus sequencer.
//
//  Channel  Ports                          Beat
//  -------  -----------------------------  ----------------------------------------
//  input    in_valid, in_stall, in_item    command or tick, one bus tick per beat
//  result   out_valid, out_stall, out_item SCL/SDA levels, busy, done, ack, read data
//  config   cfg_we, cfg_wdata              ticks per quarter bit phase
//
// One beat per clock unless the result stalls; the queue is written at the accepting
// edge and the sequencer step then loads the result register from the queue head.
// The four-entry queue and result register take up to five beats in a result stall.
// Reset, synchronous and active low, leaves the bus idle with ticks per phase at one.
`default_nettype none
module i2c_master_register_access_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire i2cm_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output i2cm_pkg::out_item_t      out_item,
  input  wire logic                cfg_we,
  input  wire logic [7:0]          cfg_wdata
);
  import i2cm_pkg::*;

  logic [7:0] tpp_r;
  q_push_t    push;
  q_head_t    head;
  logic       q_full;
  logic       pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpp_r <= 8'd1;
    end else if (cfg_we) begin
      tpp_r <= cfg_wdata;
    end
  end

  i2cm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .push_o   (push)
  );

  i2cm_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .pop    (pop),
    .full   (q_full),
    .head_o (head)
  );

  i2cm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .tpp_cfg   (tpp_r),
    .head_i    (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
